/* hdl/ppt_pkg.sv */
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared constants and types for the playback position transport: command
// codes, run modes, register indexes, field widths and divider status.
// ----------------------------------------------------------------------------
package ppt_pkg;

   localparam int POS_WIDTH_DEFAULT = 32;

   // fixed field widths
   localparam int POS_FIELD_W = 32;
   localparam int OP_W        = 3;
   localparam int STEP_W      = 16;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   // commands
   localparam logic [OP_W-1:0] OP_PLAY    = 3'd0;
   localparam logic [OP_W-1:0] OP_PAUSE   = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
   localparam logic [OP_W-1:0] OP_SEEK    = 3'd3;
   localparam logic [OP_W-1:0] OP_ADVANCE = 3'd4;

   // run modes
   localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_START   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_END     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ENABLE  = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } ppt_div_status_type;

endpackage

/* hdl/ppt_rem_unit.sv */
// ----------------------------------------------------------------------------
// ppt_rem_unit
// Restoring radix-2 remainder unit: one quotient bit per cycle, POS_WIDTH+1
// steps, remainder held until the next start.
// ----------------------------------------------------------------------------
module ppt_rem_unit
   import ppt_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [POS_WIDTH:0]   dividend,
   input  logic [POS_WIDTH-1:0] divisor,
   output ppt_div_status_type   status,
   output logic [POS_WIDTH-1:0] remainder
);

   localparam int STEPS = POS_WIDTH + 1;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [POS_WIDTH:0]   num_ff, num_in;
   logic [POS_WIDTH-1:0] rem_ff, rem_in;
   logic [POS_WIDTH-1:0] den_ff, den_in;

   logic [POS_WIDTH:0]   trial;
   logic [POS_WIDTH:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, num_ff[POS_WIDTH]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[POS_WIDTH-1:0] : trial[POS_WIDTH-1:0];
         num_in = {num_ff[POS_WIDTH-1:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("remainder unit not busy after start");

   a_done_rem : assert property (@(posedge clock) disable iff (reset)
      done_ff && den_ff != '0 |-> rem_ff < den_ff)
      else $error("remainder not below divisor");

endmodule

/* hdl/playback_position_transport_top.sv */
// ----------------------------------------------------------------------------
// playback_position_transport_top
// Audio playback transport: sample position and run state, driven by play,
// pause, stop, seek and advance commands, with optional loop wrapping.
//
//  channel  ports                              direction  handshake
//  request  req_op, req_seek_target,           in         req_valid/req_ready
//           req_step_count
//  response rsp_position, rsp_run_mode,        out        rsp_valid/rsp_ready
//           rsp_changed
//  csr      csr_index, csr_wdata               in         csr_we, no wait
//
// A result is registered through the PREP, EVAL and OUT states after its
// request transfer, and the next request can transfer once the sequencer is
// back in IDLE; a wrapping loop advance also waits in DIV on the remainder unit.
// One command is in the sequencer at a time; req_ready is high only when idle.
// A result still waiting on rsp_ready holds the next one in the output state.
// Reset clears position, run mode, response valid and all configuration registers.
// ----------------------------------------------------------------------------
module playback_position_transport_top
   import ppt_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_W-1:0]        req_op,
   input  logic [POS_FIELD_W-1:0] req_seek_target,
   input  logic [STEP_W-1:0]      req_step_count,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [POS_FIELD_W-1:0] rsp_position,
   output logic [MODE_W-1:0]      rsp_run_mode,
   output logic                   rsp_changed,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]             state_ff, state_in;

   logic [POS_WIDTH-1:0]   total_ff, lstart_ff, lend_ff;
   logic                   loop_en_ff;

   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [MODE_W-1:0]      run_ff, run_in;
   logic                   chg_ff, chg_in;

   logic [OP_W-1:0]        op_ff, op_in;
   logic [POS_WIDTH-1:0]   target_ff, target_in;
   logic [STEP_W-1:0]      step_ff, step_in;

   logic [POS_WIDTH-1:0]   ls_ff, ls_in;
   logic [POS_WIDTH-1:0]   le_ff, le_in;
   logic [POS_WIDTH-1:0]   sc_ff, sc_in;
   logic [POS_WIDTH:0]     adv_ff, adv_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [POS_FIELD_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [MODE_W-1:0]      rsp_mode_ff, rsp_mode_in;
   logic                   rsp_chg_ff, rsp_chg_in;

   logic                   div_start;
   logic [POS_WIDTH:0]     div_dividend;
   logic [POS_WIDTH-1:0]   div_divisor;
   logic [POS_WIDTH-1:0]   div_rem;
   ppt_div_status_type     div_status;

   logic                   looping;
   logic [POS_WIDTH-1:0]   seek_pos;
   logic                   req_xfer;
   logic                   rsp_load;

   assign req_xfer     = req_valid && req_ready;
   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_load     = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   assign looping      = loop_en_ff && (le_ff > ls_ff);
   assign seek_pos     = (looping && sc_ff > le_ff) ? le_ff : sc_ff;
   assign div_dividend = adv_ff - {1'b0, le_ff};
   assign div_divisor  = le_ff - ls_ff;

   ppt_rem_unit #(
      .POS_WIDTH (POS_WIDTH)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .remainder (div_rem)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         lstart_ff  <= '0;
         lend_ff    <= '0;
         loop_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_LENGTH: total_ff   <= POS_WIDTH'(csr_wdata);
            CSR_LOOP_START:   lstart_ff  <= POS_WIDTH'(csr_wdata);
            CSR_LOOP_END:     lend_ff    <= POS_WIDTH'(csr_wdata);
            CSR_LOOP_ENABLE:  loop_en_ff <= csr_wdata[0];
            default:          loop_en_ff <= loop_en_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      run_in       = run_ff;
      chg_in       = chg_ff;
      op_in        = op_ff;
      target_in    = target_ff;
      step_in      = step_ff;
      ls_in        = ls_ff;
      le_in        = le_ff;
      sc_in        = sc_ff;
      adv_in       = adv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_chg_in   = rsp_chg_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in     = req_op;
               target_in = POS_WIDTH'(req_seek_target);
               step_in   = req_step_count;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            // clamp loop bounds and seek target, form the advanced position
            ls_in    = (lstart_ff < total_ff) ? lstart_ff : total_ff;
            le_in    = (lend_ff < total_ff) ? lend_ff : total_ff;
            sc_in    = (target_ff < total_ff) ? target_ff : total_ff;
            adv_in   = {1'b0, pos_ff} + (POS_WIDTH + 1)'(step_ff);
            state_in = S_EVAL;
         end
         S_EVAL: begin
            chg_in   = 1'b0;
            state_in = S_OUT;
            case (op_ff)
               OP_PLAY: begin
                  if (total_ff != '0) begin
                     if (pos_ff >= total_ff) pos_in = '0;
                     run_in = MODE_PLAYING;
                     chg_in = 1'b1;
                  end
               end
               OP_PAUSE: begin
                  if (run_ff == MODE_PLAYING) begin
                     run_in = MODE_PAUSED;
                     chg_in = 1'b1;
                  end
               end
               OP_STOP: begin
                  pos_in = '0;
                  run_in = MODE_STOPPED;
                  chg_in = 1'b1;
               end
               OP_SEEK: begin
                  pos_in = seek_pos;
                  // seek_pos never exceeds the total, so equality marks the end
                  if (seek_pos == total_ff && total_ff != '0 && run_ff == MODE_PLAYING)
                     run_in = MODE_PAUSED;
                  chg_in = 1'b1;
               end
               OP_ADVANCE: begin
                  if (run_ff == MODE_PLAYING && total_ff != '0 && step_ff != '0) begin
                     chg_in = 1'b1;
                     if (looping) begin
                        if (adv_ff >= {1'b0, le_ff}) begin
                           div_start = 1'b1;
                           state_in  = S_DIV;
                        end else begin
                           pos_in = adv_ff[POS_WIDTH-1:0];
                        end
                     end else if (adv_ff >= {1'b0, total_ff}) begin
                        pos_in = total_ff;
                        run_in = MODE_PAUSED;
                     end else begin
                        pos_in = adv_ff[POS_WIDTH-1:0];
                     end
                  end
               end
               default: chg_in = 1'b0;
            endcase
         end
         S_DIV: begin
            if (div_status.done) begin
               pos_in   = ls_ff + div_rem;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = POS_FIELD_W'(pos_ff);
               rsp_mode_in  = run_ff;
               rsp_chg_in   = chg_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         run_ff       <= MODE_STOPPED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chg_ff      <= chg_in;
      op_ff       <= op_in;
      target_ff   <= target_in;
      step_ff     <= step_in;
      ls_ff       <= ls_in;
      le_ff       <= le_in;
      sc_ff       <= sc_in;
      adv_ff      <= adv_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_mode_ff <= rsp_mode_in;
      rsp_chg_ff  <= rsp_chg_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_run_mode = rsp_mode_ff;
   assign rsp_changed  = rsp_chg_ff;

   a_xfer_prep : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_PREP)
      else $error("request transfer did not start the sequencer");

   a_div_alive : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> (div_status.busy || div_status.done))
      else $error("waiting on an idle remainder unit");

   a_idle_div : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !div_status.busy)
      else $error("remainder unit busy while idle");

endmodule

/* tb/sv/tb_playback_position_transport_top.sv */
// ----------------------------------------------------------------------------
// tb_playback_position_transport_top
// Self-checking bench for the playback transport. Commands go in through a
// queue-fed driver with random gaps and results come back through a monitor
// with random stalls. Every accepted command is run through a local model of
// position, run mode and loop wrap, and each result is compared with it.
// ----------------------------------------------------------------------------
module tb_playback_position_transport_top;
   import ppt_pkg::*;

   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic [POS_FIELD_W-1:0] target;
      logic [STEP_W-1:0]      step;
   } transport_cmd_type;

   typedef struct packed {
      logic [POS_FIELD_W-1:0] position;
      logic [MODE_W-1:0]      mode;
      logic                   changed;
   } transport_status_type;

   // codes the block must ignore
   localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_ADVANCE + 3'd1;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;

   localparam int unsigned RANDOM_TARGET = 1350;
   localparam int unsigned HOLD_CYCLES   = 400;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OP_W-1:0]        req_op = OP_PLAY;
   logic [POS_FIELD_W-1:0] req_seek_target = '0;
   logic [STEP_W-1:0]      req_step_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [POS_FIELD_W-1:0] rsp_position;
   logic [MODE_W-1:0]      rsp_run_mode;
   logic                   rsp_changed;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_TOTAL_LENGTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // register copies and transport state of the local model
   logic [31:0]       cfg_total = '0;
   logic [31:0]       cfg_loop_start = '0;
   logic [31:0]       cfg_loop_end = '0;
   logic              cfg_loop_en = 1'b0;
   logic [31:0]       model_pos = '0;
   logic [MODE_W-1:0] model_mode = MODE_STOPPED;

   transport_cmd_type    pending_cmds[$];
   transport_status_type awaited_status[$];
   transport_cmd_type    next_cmd;
   transport_cmd_type    seen_cmd;
   transport_status_type got_status;
   transport_status_type want_status;

   int unsigned cmds_queued = 0;
   int unsigned cmds_accepted = 0;
   int unsigned mismatch_count = 0;
   int unsigned req_gap = 0;
   int unsigned req_burst = 0;
   int unsigned rsp_stall = 0;
   int unsigned rsp_burst = 0;
   int unsigned hold_left = 0;
   bit          req_took = 1'b0;
   bit          rsp_took = 1'b0;
   bit          rsp_live = 1'b0;
   bit          hold_req = 1'b0;

   playback_position_transport_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_seek_target (req_seek_target),
      .req_step_count  (req_step_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_run_mode    (rsp_run_mode),
      .rsp_changed     (rsp_changed),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one command to the model state and returns the status it reports.
   function automatic transport_status_type predict_transport(input transport_cmd_type c);
      logic [31:0]          ls;
      logic [31:0]          le;
      logic [31:0]          len;
      logic [32:0]          adv;
      logic [32:0]          rem;
      logic                 looping;
      transport_status_type s;
      ls = (cfg_loop_start < cfg_total) ? cfg_loop_start : cfg_total;
      le = (cfg_loop_end < cfg_total) ? cfg_loop_end : cfg_total;
      looping = cfg_loop_en && (le > ls);
      s.changed = 1'b0;
      case (c.op)
         OP_PLAY: begin
            if (cfg_total != 0) begin
               if (model_pos >= cfg_total)
                  model_pos = '0;
               model_mode = MODE_PLAYING;
               s.changed = 1'b1;
            end
         end
         OP_PAUSE: begin
            if (model_mode == MODE_PLAYING) begin
               model_mode = MODE_PAUSED;
               s.changed = 1'b1;
            end
         end
         OP_STOP: begin
            model_mode = MODE_STOPPED;
            model_pos = '0;
            s.changed = 1'b1;
         end
         OP_SEEK: begin
            model_pos = (c.target < cfg_total) ? c.target : cfg_total;
            if (looping && model_pos > le)
               model_pos = le;
            if (model_pos >= cfg_total && cfg_total != 0 && model_mode == MODE_PLAYING)
               model_mode = MODE_PAUSED;
            s.changed = 1'b1;
         end
         OP_ADVANCE: begin
            if (model_mode == MODE_PLAYING && cfg_total != 0 && c.step != 0) begin
               adv = {1'b0, model_pos} + c.step;
               if (looping) begin
                  if (adv >= {1'b0, le}) begin
                     // overshoot folds back into the loop
                     len = le - ls;
                     rem = (adv - {1'b0, le}) % {1'b0, len};
                     model_pos = ls + rem[31:0];
                  end else begin
                     model_pos = adv[31:0];
                  end
               end else if (adv >= {1'b0, cfg_total}) begin
                  model_pos = cfg_total;
                  model_mode = MODE_PAUSED;
               end else begin
                  model_pos = adv[31:0];
               end
               s.changed = 1'b1;
            end
         end
         default: ;
      endcase
      s.position = model_pos;
      s.mode = model_mode;
      return s;
   endfunction

   // Wait length for one transfer, with occasional runs of back-to-back items.
   function automatic int unsigned pick_wait(inout int unsigned burst);
      if (burst != 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   // request side: predict at each transfer
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         seen_cmd.op = req_op;
         seen_cmd.target = req_seek_target;
         seen_cmd.step = req_step_count;
         awaited_status.push_back(predict_transport(seen_cmd));
         cmds_accepted++;
         req_took = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         req_took = 1'b0;
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            next_cmd = pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_op <= next_cmd.op;
            req_seek_target <= next_cmd.target;
            req_step_count <= next_cmd.step;
            req_gap = pick_wait(req_burst);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: check each transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_live = 1'b0;
      if (!reset && rsp_valid) begin
         if (rsp_ready) begin
            rsp_took = 1'b1;
            got_status.position = rsp_position;
            got_status.mode = rsp_run_mode;
            got_status.changed = rsp_changed;
            if (awaited_status.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: position %0d mode %0d changed %0d",
                           got_status.position, got_status.mode, got_status.changed);
            end else begin
               want_status = awaited_status.pop_front();
               if (want_status.position !== got_status.position ||
                   want_status.mode !== got_status.mode ||
                   want_status.changed !== got_status.changed) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: position exp %0d got %0d, mode exp %0d got %0d, %s",
                              want_status.position, got_status.position,
                              want_status.mode, got_status.mode,
                              $sformatf("changed exp %0d got %0d",
                                        want_status.changed, got_status.changed));
               end
            end
         end else begin
            rsp_live = 1'b1;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_took) begin
            rsp_took = 1'b0;
            rsp_stall = pick_wait(rsp_burst);
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else if (rsp_stall != 0) begin
            // stall only counts down while a result is actually waiting
            if (rsp_live)
               rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [31:0] target,
                            input logic [15:0] step);
      transport_cmd_type c;
      c.op = op;
      c.target = target;
      c.step = step;
      pending_cmds.push_back(c);
      cmds_queued++;
   endtask

   task automatic wait_idle;
      while (cmds_accepted != cmds_queued || awaited_status.size() != 0)
         @(posedge clock);
      while (req_ready !== 1'b1)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_TOTAL_LENGTH: cfg_total = data;
         CSR_LOOP_START:   cfg_loop_start = data;
         CSR_LOOP_END:     cfg_loop_end = data;
         CSR_LOOP_ENABLE:  cfg_loop_en = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Some registers keep their old value, so stale positions come up.
   task automatic random_setup;
      logic [31:0] v;
      if ($urandom_range(0, 4) != 0) begin
         case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = $urandom;
            default: v = $urandom_range(1, 3000);
         endcase
         csr_write(CSR_TOTAL_LENGTH, v);
      end
      if ($urandom_range(0, 4) != 0) begin
         case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = $urandom;
            default: v = $urandom_range(0, cfg_total);
         endcase
         csr_write(CSR_LOOP_START, v);
      end
      if ($urandom_range(0, 4) != 0) begin
         case ($urandom_range(0, 7))
            0: v = '1;
            1: v = $urandom_range(0, cfg_loop_start);
            2: v = $urandom;
            default: v = cfg_loop_start + $urandom_range(1, 2000);
         endcase
         csr_write(CSR_LOOP_END, v);
      end
      if ($urandom_range(0, 4) != 0) begin
         v = $urandom;
         v[0] = ($urandom_range(0, 3) != 0);
         csr_write(CSR_LOOP_ENABLE, v);
      end
   endtask

   task automatic random_burst(input int unsigned n, output int unsigned counted);
      logic [OP_W-1:0] op;
      logic [31:0]     target;
      logic [31:0]     span;
      logic [15:0]     step;
      int unsigned     r;
      counted = 0;
      span = cfg_total / 8;
      if (span == 0)
         span = 1;
      if (span > 32'hFFFF)
         span = 32'hFFFF;
      // sessions mostly open with play so advances get somewhere
      if (cfg_total != 0) begin
         queue_cmd(OP_PLAY, $urandom, $urandom);
         counted++;
      end
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 12)
            op = OP_PLAY;
         else if (r < 19)
            op = OP_PAUSE;
         else if (r < 24)
            op = OP_STOP;
         else if (r < 40)
            op = OP_SEEK;
         else if (r < 97)
            op = OP_ADVANCE;
         else
            op = OP_ADVANCE + 3'($urandom_range(1, 3));
         case ($urandom_range(0, 5))
            0: target = $urandom;
            1: target = '1;
            2: target = $urandom_range(0, cfg_total);
            3: target = cfg_loop_end - 2 + $urandom_range(0, 4);
            4: target = cfg_total - $urandom_range(0, 2);
            default: target = $urandom_range(0, 64);
         endcase
         case ($urandom_range(0, 9))
            0: step = '0;
            1: step = '1;
            2: step = 16'($urandom);
            default: step = 16'($urandom_range(1, span));
         endcase
         queue_cmd(op, target, step);
         if (op <= OP_ADVANCE)
            counted++;
      end
   endtask

   initial begin : stimulus
      int unsigned random_items;
      int unsigned phase_count;
      int unsigned got_items;
      random_items = 0;
      phase_count = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty timeline: nothing can play
      queue_cmd(OP_PLAY, '0, '0);
      queue_cmd(OP_ADVANCE, '0, 16'd100);
      queue_cmd(OP_PAUSE, '0, '0);
      queue_cmd(OP_SEEK, '1, '0);
      queue_cmd(OP_UNUSED_LO, '1, '1);
      wait_idle;

      // loop 100..300 within 1000, receiver held off while commands queue up
      csr_write(CSR_TOTAL_LENGTH, 32'd1000);
      csr_write(CSR_LOOP_START, 32'd100);
      csr_write(CSR_LOOP_END, 32'd300);
      csr_write(CSR_LOOP_ENABLE, 32'd1);
      @(negedge clock);
      hold_req = 1'b1;
      queue_cmd(OP_SEEK, 32'd500, '0);
      queue_cmd(OP_ADVANCE, '0, 16'd10);
      queue_cmd(OP_PLAY, '0, '0);
      queue_cmd(OP_ADVANCE, '0, '0);
      queue_cmd(OP_ADVANCE, '0, '1);
      queue_cmd(OP_ADVANCE, '0, 16'd65);
      queue_cmd(OP_PAUSE, '0, '0);
      queue_cmd(OP_PAUSE, '0, '0);
      queue_cmd(OP_PLAY, '0, '0);
      queue_cmd(OP_STOP, '1, '1);
      wait_idle;

      // no loop: run into the end, pause there, restart
      csr_write(CSR_LOOP_ENABLE, 32'hFFFF_FFFE);
      csr_write(CSR_LOOP_END, '1);
      queue_cmd(OP_PLAY, '0, '0);
      queue_cmd(OP_SEEK, 32'd990, '0);
      queue_cmd(OP_ADVANCE, '0, 16'd10);
      queue_cmd(OP_PLAY, '0, '0);
      queue_cmd(OP_SEEK, 32'd1000, '0);
      wait_idle;

      // full-range timeline, degenerate loop
      csr_write(CSR_TOTAL_LENGTH, '1);
      csr_write(CSR_LOOP_START, '1);
      csr_write(CSR_LOOP_ENABLE, '1);
      queue_cmd(OP_PLAY, '0, '0);
      queue_cmd(OP_SEEK, 32'hFFFF_FFFE, '0);
      queue_cmd(OP_ADVANCE, '0, '1);
      wait_idle;

      // shrink the timeline under a stale position
      csr_write(CSR_TOTAL_LENGTH, 32'd500);
      csr_write(CSR_LOOP_START, '0);
      csr_write(CSR_LOOP_END, 32'd100);
      queue_cmd(OP_ADVANCE, '0, 16'd5);
      queue_cmd(OP_PLAY, '0, '0);
      queue_cmd(OP_UNUSED_HI, '0, '0);

      while (random_items < RANDOM_TARGET) begin
         wait_idle;
         random_setup;
         if (phase_count % 6 == 3) begin
            @(negedge clock);
            hold_req = 1'b1;
         end
         random_burst($urandom_range(30, 70), got_items);
         random_items += got_items;
         phase_count++;
      end

      wait_idle;
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("** playback_position_transport_top: PASSED **");
      else
         $display("** playback_position_transport_top: FAILED **");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** playback_position_transport_top: FAILED **");
      $finish;
   end

endmodule
